// ===== sv/twr_pkg.sv =====
// ----------------------------------------------------------------------------
// twr_pkg: shared definitions for the tiled region walker
// Default sizes, register indexes, reset values and the command and status
// bundles between the walk controller and the datapath.
// ----------------------------------------------------------------------------
package twr_pkg;

  // default sizes
  localparam int COORD_BITS_DEF    = 24;
  localparam int TILE_DIM_BITS_DEF = 12;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_COLS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_ROWS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y       = 3'd7;

  // tile size after reset
  localparam int TILE_COLS_RST = 128;
  localparam int TILE_ROWS_RST = 64;

  // controller to datapath commands
  typedef struct packed {
    logic accept;       // input transfer this cycle
    logic div_start;    // launch the divider
    logic div_y;        // divider works on the vertical axis
    logic band_update;  // move to the next row band
    logic capture_x;    // keep column quotient and remainder
    logic capture_y;    // keep row quotient and remainder
    logic piece_calc;   // clip piece size, form pixel offset product
    logic load_piece;   // load a piece into the output register
    logic load_done;    // load a done result into the output register
  } twr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic walk_done;
    logic col_past;
    logic row_past;
    logic div_busy;
    logic div_done;
    logic out_free;
  } twr_sts_t;

endpackage

// ===== sv/twr_div.sv =====
// ----------------------------------------------------------------------------
// twr_div: floor division unit
// Signed dividend over a positive tile dimension, one quotient bit per cycle,
// then a sign fix-up state giving floor quotient and floor remainder.
// ----------------------------------------------------------------------------
module twr_div
  import twr_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int TILE_DIM_BITS = TILE_DIM_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [COORD_BITS+1:0]    dividend,
  input  logic [TILE_DIM_BITS:0]   divisor,
  output logic                     busy,
  output logic                     done,
  output logic [COORD_BITS:0]      quot,
  output logic [TILE_DIM_BITS-1:0] rmd
);

  localparam int DW    = COORD_BITS + 2;
  localparam int CNT_W = $clog2(DW);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} div_state_t;

  div_state_t               state_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [DW-1:0]            q_r;
  logic [TILE_DIM_BITS:0]   rem_r;
  logic [TILE_DIM_BITS:0]   d_r;
  logic                     neg_r;
  logic                     done_r;
  logic [COORD_BITS:0]      quot_r;
  logic [TILE_DIM_BITS-1:0] rmd_r;

  logic [DW-1:0]            mag;
  logic [TILE_DIM_BITS+1:0] trial;
  logic                     fits;
  logic [TILE_DIM_BITS:0]   rem_nxt;
  logic [DW-1:0]            q_fix;
  logic [TILE_DIM_BITS:0]   r_fix;

  // magnitude of the dividend
  assign mag = dividend[DW-1] ? (~dividend + DW'(1)) : dividend;

  // restoring step
  always_comb begin
    trial   = {rem_r, q_r[DW-1]};
    fits    = trial >= {1'b0, d_r};
    rem_nxt = fits ? (TILE_DIM_BITS+1)'(trial - {1'b0, d_r}) : trial[TILE_DIM_BITS:0];
  end

  // floor correction for a negative dividend
  always_comb begin
    q_fix = q_r;
    r_fix = rem_r;
    if (neg_r) begin
      if (rem_r != '0) begin
        q_fix = ~q_r;
        r_fix = d_r - rem_r;
      end else begin
        q_fix = ~q_r + DW'(1);
      end
    end
  end

  // sequencer and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (start) begin
            q_r     <= mag;
            rem_r   <= '0;
            d_r     <= divisor;
            neg_r   <= dividend[DW-1];
            cnt_r   <= CNT_W'(DW - 1);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          q_r   <= {q_r[DW-2:0], fits};
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= D_FIX;
          end
        end
        D_FIX: begin
          quot_r  <= q_fix[COORD_BITS:0];
          rmd_r   <= r_fix[TILE_DIM_BITS-1:0];
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign busy = (state_r != D_IDLE);
  assign done = done_r;
  assign quot = quot_r;
  assign rmd  = rmd_r;

  // remainder always below the divisor it was formed with
  a_rmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ({1'b0, rmd_r} < d_r))
    else $error("divider remainder not below divisor");

endmodule

// ===== sv/twr_dp.sv =====
// ----------------------------------------------------------------------------
// twr_dp: walker datapath
// Configuration registers, walk progress, the shared divider, piece clipping
// and the output register.
// ----------------------------------------------------------------------------
module twr_dp
  import twr_pkg::*;
#(
  parameter  int COORD_BITS    = COORD_BITS_DEF,
  parameter  int TILE_DIM_BITS = TILE_DIM_BITS_DEF,
  localparam int CFG_W         = (COORD_BITS > TILE_DIM_BITS) ? COORD_BITS : TILE_DIM_BITS + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_restart,
  input  logic                          out_stall,
  input  twr_cmd_t                      cmd,
  output twr_sts_t                      sts,
  output logic                          out_valid,
  output logic                          out_piece_valid,
  output logic signed [COORD_BITS:0]    out_tile_col_index,
  output logic signed [COORD_BITS:0]    out_tile_row_index,
  output logic [TILE_DIM_BITS-1:0]      out_offset_in_tile_x,
  output logic [TILE_DIM_BITS-1:0]      out_offset_in_tile_y,
  output logic [TILE_DIM_BITS:0]        out_piece_width,
  output logic [TILE_DIM_BITS:0]        out_piece_height,
  output logic signed [COORD_BITS:0]    out_piece_x,
  output logic signed [COORD_BITS:0]    out_piece_y,
  output logic [2*TILE_DIM_BITS-1:0]    out_pixel_offset,
  output logic                          out_full_width,
  output logic                          out_full_tile
);

  localparam int CB     = COORD_BITS;
  localparam int TDB    = TILE_DIM_BITS;
  localparam int DW     = CB + 2;
  localparam int CMP_W  = CFG_W + 1;
  localparam int PROD_W = 2 * TDB + 1;
  localparam int TC_RST = (TILE_COLS_RST > (1 << TDB)) ? (1 << TDB) : TILE_COLS_RST;
  localparam int TR_RST = (TILE_ROWS_RST > (1 << TDB)) ? (1 << TDB) : TILE_ROWS_RST;
  localparam logic [TDB:0] TILE_MAX = {1'b1, {TDB{1'b0}}};

  // configuration registers
  logic [CB-1:0] region_x_r, region_y_r, shift_x_r, shift_y_r;
  logic [CB-2:0] region_w_r, region_h_r;
  logic [TDB:0]  tile_cols_r, tile_rows_r;

  // walk state
  logic [CB-1:0] col_progress_r, row_progress_r;
  logic          walk_done_r;

  // per-piece working registers
  logic [CB:0]       qx_r, qy_r;
  logic [TDB-1:0]    offx_r, offy_r;
  logic [TDB:0]      pw_r, ph_r;
  logic [PROD_W-1:0] prod_r;

  // output register
  logic                 out_valid_r, out_piece_valid_r, out_full_width_r, out_full_tile_r;
  logic [CB:0]          out_tcol_r, out_trow_r, out_px_r, out_py_r;
  logic [TDB-1:0]       out_offx_r, out_offy_r;
  logic [TDB:0]         out_pw_r, out_ph_r;
  logic [2*TDB-1:0]     out_pixoff_r;

  // effective sizes
  logic [CB-2:0] rw, rh;
  logic [TDB:0]  tc, tr;

  // divider hookup
  logic [DW-1:0]  div_dividend;
  logic [TDB:0]   div_divisor;
  logic           div_busy, div_done;
  logic [CB:0]    div_quot;
  logic [TDB-1:0] div_rmd;

  // arithmetic helpers
  logic [CMP_W-1:0] span_x, span_y, room_x, room_y, pw_sel, ph_sel;
  logic [CMP_W-1:0] row_step, col_step;
  logic             out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_x_r  <= '0;
      region_y_r  <= '0;
      region_w_r  <= (CB-1)'(1);
      region_h_r  <= (CB-1)'(1);
      tile_cols_r <= (TDB+1)'(TC_RST);
      tile_rows_r <= (TDB+1)'(TR_RST);
      shift_x_r   <= '0;
      shift_y_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REGION_X:      region_x_r  <= cfg_data[CB-1:0];
        REG_REGION_Y:      region_y_r  <= cfg_data[CB-1:0];
        REG_REGION_WIDTH:  region_w_r  <= cfg_data[CB-2:0];
        REG_REGION_HEIGHT: region_h_r  <= cfg_data[CB-2:0];
        REG_TILE_COLS:     tile_cols_r <= cfg_data[TDB:0];
        REG_TILE_ROWS:     tile_rows_r <= cfg_data[TDB:0];
        REG_SHIFT_X:       shift_x_r   <= cfg_data[CB-1:0];
        REG_SHIFT_Y:       shift_y_r   <= cfg_data[CB-1:0];
        default: ;
      endcase
    end
  end

  // zero size reads as one, tile size saturates
  always_comb begin
    rw = (region_w_r == '0) ? (CB-1)'(1) : region_w_r;
    rh = (region_h_r == '0) ? (CB-1)'(1) : region_h_r;
    tc = tile_cols_r[TDB] ? TILE_MAX : ((tile_cols_r == '0) ? (TDB+1)'(1) : tile_cols_r);
    tr = tile_rows_r[TDB] ? TILE_MAX : ((tile_rows_r == '0) ? (TDB+1)'(1) : tile_rows_r);
  end

  // shifted coordinate of the current position
  always_comb begin
    if (cmd.div_y) begin
      div_dividend = {{2{region_y_r[CB-1]}}, region_y_r} + {{2{shift_y_r[CB-1]}}, shift_y_r}
                   + {2'b00, row_progress_r};
      div_divisor  = tr;
    end else begin
      div_dividend = {{2{region_x_r[CB-1]}}, region_x_r} + {{2{shift_x_r[CB-1]}}, shift_x_r}
                   + {2'b00, col_progress_r};
      div_divisor  = tc;
    end
  end

  twr_div #(
    .COORD_BITS    (COORD_BITS),
    .TILE_DIM_BITS (TILE_DIM_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rmd      (div_rmd)
  );

  // clipping and progress steps
  always_comb begin
    span_x   = CMP_W'(rw) - CMP_W'(col_progress_r);
    span_y   = CMP_W'(rh) - CMP_W'(row_progress_r);
    room_x   = CMP_W'(tc) - CMP_W'(offx_r);
    room_y   = CMP_W'(tr) - CMP_W'(offy_r);
    pw_sel   = (span_x < room_x) ? span_x : room_x;
    ph_sel   = (span_y < room_y) ? span_y : room_y;
    row_step = CMP_W'(row_progress_r) + CMP_W'(tr) - CMP_W'(div_rmd);
    col_step = CMP_W'(col_progress_r) + room_x;
  end

  // walk progress
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_progress_r <= '0;
      row_progress_r <= '0;
      walk_done_r    <= 1'b0;
    end else begin
      if (cmd.accept && in_restart) begin
        col_progress_r <= '0;
        row_progress_r <= '0;
        walk_done_r    <= 1'b0;
      end
      if (cmd.band_update) begin
        col_progress_r <= '0;
        row_progress_r <= row_step[CB-1:0];
      end
      if (cmd.load_piece) begin
        col_progress_r <= col_step[CB-1:0];
      end
      if (cmd.load_done) begin
        walk_done_r <= 1'b1;
      end
    end
  end

  // piece working values
  always_ff @(posedge clk) begin
    if (cmd.capture_x) begin
      qx_r   <= div_quot;
      offx_r <= div_rmd;
    end
    if (cmd.capture_y) begin
      qy_r   <= div_quot;
      offy_r <= div_rmd;
    end
    if (cmd.piece_calc) begin
      pw_r   <= pw_sel[TDB:0];
      ph_r   <= ph_sel[TDB:0];
      prod_r <= PROD_W'(offy_r) * PROD_W'(tc);
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_piece || cmd.load_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.load_piece) begin
      out_piece_valid_r <= 1'b1;
      out_tcol_r        <= qx_r;
      out_trow_r        <= qy_r;
      out_offx_r        <= offx_r;
      out_offy_r        <= offy_r;
      out_pw_r          <= pw_r;
      out_ph_r          <= ph_r;
      out_px_r          <= {region_x_r[CB-1], region_x_r} + {1'b0, col_progress_r};
      out_py_r          <= {region_y_r[CB-1], region_y_r} + {1'b0, row_progress_r};
      out_pixoff_r      <= (2*TDB)'(prod_r + PROD_W'(offx_r));
      out_full_width_r  <= (pw_r == tc);
      out_full_tile_r   <= (pw_r == tc) && (ph_r == tr);
    end else if (cmd.load_done) begin
      out_piece_valid_r <= 1'b0;
      out_tcol_r        <= '0;
      out_trow_r        <= '0;
      out_offx_r        <= '0;
      out_offy_r        <= '0;
      out_pw_r          <= '0;
      out_ph_r          <= '0;
      out_px_r          <= '0;
      out_py_r          <= '0;
      out_pixoff_r      <= '0;
      out_full_width_r  <= 1'b0;
      out_full_tile_r   <= 1'b0;
    end
  end

  // status to the controller
  always_comb begin
    sts.walk_done = walk_done_r;
    sts.col_past  = ({1'b0, rw} <= col_progress_r);
    sts.row_past  = ({1'b0, rh} <= row_progress_r);
    sts.div_busy  = div_busy;
    sts.div_done  = div_done;
    sts.out_free  = out_free;
  end

  assign out_valid            = out_valid_r;
  assign out_piece_valid      = out_piece_valid_r;
  assign out_tile_col_index   = out_tcol_r;
  assign out_tile_row_index   = out_trow_r;
  assign out_offset_in_tile_x = out_offx_r;
  assign out_offset_in_tile_y = out_offy_r;
  assign out_piece_width      = out_pw_r;
  assign out_piece_height     = out_ph_r;
  assign out_piece_x          = out_px_r;
  assign out_piece_y          = out_py_r;
  assign out_pixel_offset     = out_pixoff_r;
  assign out_full_width       = out_full_width_r;
  assign out_full_tile        = out_full_tile_r;

  // a done result leaves the walk finished and shows as a done transfer
  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_done |=> (walk_done_r && out_valid_r && !out_piece_valid_r))
    else $error("done result not loaded");

  // a delivered piece is never empty
  a_piece_size: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_piece |=> (out_pw_r != '0 && out_ph_r != '0))
    else $error("empty piece loaded");

endmodule

// ===== sv/twr_ctrl.sv =====
// ----------------------------------------------------------------------------
// twr_ctrl: walk controller
// Sequences one request: band advance, column and row divisions, clipping
// and the hand-off to the output register.
// ----------------------------------------------------------------------------
module twr_ctrl
  import twr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  twr_sts_t sts,
  output twr_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_BAND, S_DIVX, S_DIVY, S_PIECE, S_LOAD, S_DONE
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.walk_done) begin
          state_nxt = S_DONE;
        end else if (sts.col_past) begin
          cmd.div_start = 1'b1;
          cmd.div_y     = 1'b1;
          state_nxt     = S_BAND;
        end else if (sts.row_past) begin
          state_nxt = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVX;
        end
      end
      S_BAND: begin
        cmd.div_y = 1'b1;
        if (sts.div_done) begin
          cmd.band_update = 1'b1;
          state_nxt       = S_CHECK;
        end
      end
      S_DIVX: begin
        if (sts.div_done) begin
          cmd.capture_x = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_y     = 1'b1;
          state_nxt     = S_DIVY;
        end
      end
      S_DIVY: begin
        cmd.div_y = 1'b1;
        if (sts.div_done) begin
          cmd.capture_y = 1'b1;
          state_nxt     = S_PIECE;
        end
      end
      S_PIECE: begin
        cmd.piece_calc = 1'b1;
        state_nxt      = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load_piece = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_done = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // the divider is only launched when free
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider launched while busy");

  // results only go into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_piece || cmd.load_done) |-> sts.out_free)
    else $error("output register overwritten");

endmodule

// ===== sv/tiled_region_walker.sv =====
// ----------------------------------------------------------------------------
// tiled_region_walker: tiled region scan address generator
// Cuts a region of interest into tile-aligned pieces, left to right within a
// row band and band by band downwards, one piece per request.
// ----------------------------------------------------------------------------
// Each request takes one input transfer and returns one result transfer. A
// piece needs two floor divisions on a shared divider that produces one
// quotient bit per cycle; a request that moves the walk to the next row band
// needs one division more, and a request on a finished walk needs none. One
// request is in work at a time; the next one is taken as soon as the previous
// result sits in the output register, even while that result is still
// stalled. The user must write registers only while the block is idle, which
// the block itself does not enforce; they take effect at the next request.
module tiled_region_walker
  import twr_pkg::*;
#(
  parameter  int COORD_BITS    = COORD_BITS_DEF,
  parameter  int TILE_DIM_BITS = TILE_DIM_BITS_DEF,
  localparam int CFG_W         = (COORD_BITS > TILE_DIM_BITS) ? COORD_BITS : TILE_DIM_BITS + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_piece_valid,
  output logic signed [COORD_BITS:0]    out_tile_col_index,
  output logic signed [COORD_BITS:0]    out_tile_row_index,
  output logic [TILE_DIM_BITS-1:0]      out_offset_in_tile_x,
  output logic [TILE_DIM_BITS-1:0]      out_offset_in_tile_y,
  output logic [TILE_DIM_BITS:0]        out_piece_width,
  output logic [TILE_DIM_BITS:0]        out_piece_height,
  output logic signed [COORD_BITS:0]    out_piece_x,
  output logic signed [COORD_BITS:0]    out_piece_y,
  output logic [2*TILE_DIM_BITS-1:0]    out_pixel_offset,
  output logic                          out_full_width,
  output logic                          out_full_tile
);

  twr_cmd_t cmd;
  twr_sts_t sts;

  // walk sequencing
  twr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // registers, arithmetic and output register
  twr_dp #(
    .COORD_BITS    (COORD_BITS),
    .TILE_DIM_BITS (TILE_DIM_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_restart           (in_restart),
    .out_stall            (out_stall),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_valid            (out_valid),
    .out_piece_valid      (out_piece_valid),
    .out_tile_col_index   (out_tile_col_index),
    .out_tile_row_index   (out_tile_row_index),
    .out_offset_in_tile_x (out_offset_in_tile_x),
    .out_offset_in_tile_y (out_offset_in_tile_y),
    .out_piece_width      (out_piece_width),
    .out_piece_height     (out_piece_height),
    .out_piece_x          (out_piece_x),
    .out_piece_y          (out_piece_y),
    .out_pixel_offset     (out_pixel_offset),
    .out_full_width       (out_full_width),
    .out_full_tile        (out_full_tile)
  );

endmodule

// ===== tb/sv/twr_piece_checker.sv =====
// ----------------------------------------------------------------------------
// twr_piece_checker: piece predictor and result comparator
// Follows configuration writes and request transfers, works out the piece or
// done result that each request must produce, and compares every result
// transfer, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module twr_piece_checker
  import twr_pkg::*;
#(
  parameter  int COORD_BITS    = COORD_BITS_DEF,
  parameter  int TILE_DIM_BITS = TILE_DIM_BITS_DEF,
  localparam int CFG_W         = (COORD_BITS > TILE_DIM_BITS) ? COORD_BITS : TILE_DIM_BITS + 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_restart,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_piece_valid,
  input  logic [COORD_BITS:0]        out_tile_col_index,
  input  logic [COORD_BITS:0]        out_tile_row_index,
  input  logic [TILE_DIM_BITS-1:0]   out_offset_in_tile_x,
  input  logic [TILE_DIM_BITS-1:0]   out_offset_in_tile_y,
  input  logic [TILE_DIM_BITS:0]     out_piece_width,
  input  logic [TILE_DIM_BITS:0]     out_piece_height,
  input  logic [COORD_BITS:0]        out_piece_x,
  input  logic [COORD_BITS:0]        out_piece_y,
  input  logic [2*TILE_DIM_BITS-1:0] out_pixel_offset,
  input  logic                       out_full_width,
  input  logic                       out_full_tile,
  output int                         mismatch_count,
  output int                         pieces_waiting
);

  localparam longint COORD_MASK = (longint'(1) << COORD_BITS) - 1;
  localparam longint TILE_MAX   = longint'(1) << TILE_DIM_BITS;

  typedef struct packed {
    logic                       piece_valid;
    logic [COORD_BITS:0]        tile_col_index;
    logic [COORD_BITS:0]        tile_row_index;
    logic [TILE_DIM_BITS-1:0]   offset_x;
    logic [TILE_DIM_BITS-1:0]   offset_y;
    logic [TILE_DIM_BITS:0]     width;
    logic [TILE_DIM_BITS:0]     height;
    logic [COORD_BITS:0]        piece_x;
    logic [COORD_BITS:0]        piece_y;
    logic [2*TILE_DIM_BITS-1:0] pixel_offset;
    logic                       full_width;
    logic                       full_tile;
  } piece_t;

  // register copy, as written
  longint roi_x, roi_y, roi_w, roi_h, tile_w, tile_h, org_x, org_y;
  // walk position
  longint col_prog, row_prog;
  logic   walk_finished;

  piece_t expected_pieces[$];
  piece_t seen_piece, want_piece;
  int     n_bad;
  int     n_waiting;

  assign mismatch_count = n_bad;
  assign pieces_waiting = n_waiting;

  function automatic longint floor_mod(input longint a, input longint b);
    longint r;
    r = a % b;
    if (r < 0) r = r + b;
    return r;
  endfunction

  function automatic longint tile_clamp(input longint v);
    if (v == 0) return 1;
    if (v > TILE_MAX) return TILE_MAX;
    return v;
  endfunction

  // next piece of the walk, advances the walk position
  function automatic piece_t walk_step(input logic restart);
    piece_t p;
    longint rw, rh, tc, tr, bx, by, col, row, offx, offy, pw, ph, qx, qy, pix, px, py;
    p  = '0;
    rw = (roi_w != 0) ? roi_w : 1;
    rh = (roi_h != 0) ? roi_h : 1;
    tc = tile_clamp(tile_w);
    tr = tile_clamp(tile_h);
    bx = roi_x + org_x;
    by = roi_y + org_y;
    if (restart) begin
      col_prog      = 0;
      row_prog      = 0;
      walk_finished = 1'b0;
    end
    if (walk_finished) return p;
    col = col_prog;
    row = row_prog;
    // column past the region edge: drop to the next row band
    if (col >= rw) begin
      row      = row + tr - floor_mod(by + row, tr);
      col      = 0;
      row_prog = row & COORD_MASK;
      col_prog = 0;
    end
    if (row >= rh) begin
      walk_finished = 1'b1;
      return p;
    end
    offx     = floor_mod(bx + col, tc);
    offy     = floor_mod(by + row, tr);
    qx       = (bx + col - offx) / tc;
    qy       = (by + row - offy) / tr;
    pw       = (rw - col < tc - offx) ? rw - col : tc - offx;
    ph       = (rh - row < tr - offy) ? rh - row : tr - offy;
    col_prog = (col + tc - offx) & COORD_MASK;
    pix      = offy * tc + offx;
    px       = roi_x + col;
    py       = roi_y + row;
    p.piece_valid    = 1'b1;
    p.tile_col_index = qx[COORD_BITS:0];
    p.tile_row_index = qy[COORD_BITS:0];
    p.offset_x       = offx[TILE_DIM_BITS-1:0];
    p.offset_y       = offy[TILE_DIM_BITS-1:0];
    p.width          = pw[TILE_DIM_BITS:0];
    p.height         = ph[TILE_DIM_BITS:0];
    p.piece_x        = px[COORD_BITS:0];
    p.piece_y        = py[COORD_BITS:0];
    p.pixel_offset   = pix[2*TILE_DIM_BITS-1:0];
    p.full_width     = (pw == tc);
    p.full_tile      = (pw == tc) && (ph == tr);
    return p;
  endfunction

  function automatic string piece_text(input piece_t p);
    return $sformatf({"valid=%0d col=%0d row=%0d off=%0d,%0d size=%0dx%0d",
                      " at=%0d,%0d pix=%0d fw=%0d ft=%0d"},
                     p.piece_valid, $signed(p.tile_col_index), $signed(p.tile_row_index),
                     p.offset_x, p.offset_y, p.width, p.height,
                     $signed(p.piece_x), $signed(p.piece_y), p.pixel_offset,
                     p.full_width, p.full_tile);
  endfunction

  task automatic report_bad(input string what, input piece_t want, input piece_t seen);
    n_bad++;
    if (n_bad <= 10) begin
      $display("mismatch at %0t: %s", $realtime, what);
      $display("  expected %s", piece_text(want));
      $display("  actual   %s", piece_text(seen));
    end
  endtask

  // register writes, request transfers and result transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      roi_x         = 0;
      roi_y         = 0;
      roi_w         = 1;
      roi_h         = 1;
      tile_w        = TILE_COLS_RST;
      tile_h        = TILE_ROWS_RST;
      org_x         = 0;
      org_y         = 0;
      col_prog      = 0;
      row_prog      = 0;
      walk_finished = 1'b0;
      expected_pieces.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_REGION_X:      roi_x  = longint'($signed(cfg_data[COORD_BITS-1:0]));
          REG_REGION_Y:      roi_y  = longint'($signed(cfg_data[COORD_BITS-1:0]));
          REG_REGION_WIDTH:  roi_w  = longint'(cfg_data[COORD_BITS-2:0]);
          REG_REGION_HEIGHT: roi_h  = longint'(cfg_data[COORD_BITS-2:0]);
          REG_TILE_COLS:     tile_w = longint'(cfg_data[TILE_DIM_BITS:0]);
          REG_TILE_ROWS:     tile_h = longint'(cfg_data[TILE_DIM_BITS:0]);
          REG_SHIFT_X:       org_x  = longint'($signed(cfg_data[COORD_BITS-1:0]));
          REG_SHIFT_Y:       org_y  = longint'($signed(cfg_data[COORD_BITS-1:0]));
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_pieces.push_back(walk_step(in_restart));
      if (out_valid && !out_stall) begin
        seen_piece = {out_piece_valid, out_tile_col_index, out_tile_row_index,
                      out_offset_in_tile_x, out_offset_in_tile_y, out_piece_width,
                      out_piece_height, out_piece_x, out_piece_y, out_pixel_offset,
                      out_full_width, out_full_tile};
        if (expected_pieces.size() == 0) begin
          report_bad("result transfer with nothing outstanding", '0, seen_piece);
        end else begin
          want_piece = expected_pieces.pop_front();
          if (seen_piece !== want_piece)
            report_bad("result fields differ", want_piece, seen_piece);
        end
      end
    end
    n_waiting = expected_pieces.size();
  end

endmodule

// ===== tb/sv/tiled_region_walker_tb.sv =====
// ----------------------------------------------------------------------------
// tiled_region_walker_tb: request stimulus and verdict for the region walker
// Runs a directed opening on extreme registers, wrapping tile indices and
// regions changed mid-walk, then random walks under random register settings,
// with bursty requests, a stalling receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tiled_region_walker_tb;
  import twr_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int TD = TILE_DIM_BITS_DEF;
  localparam int CW = (CB > TD) ? CB : TD + 1;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CW-1:0] cfg_data;
  logic in_valid, in_stall, in_restart;
  logic out_valid, out_stall, out_piece_valid;
  logic signed [CB:0] out_tile_col_index, out_tile_row_index, out_piece_x, out_piece_y;
  logic [TD-1:0] out_offset_in_tile_x, out_offset_in_tile_y;
  logic [TD:0] out_piece_width, out_piece_height;
  logic [2*TD-1:0] out_pixel_offset;
  logic out_full_width, out_full_tile;

  int mismatch_count;
  int pieces_waiting;
  int requests_sent;
  int burst_left;
  bit hold_done;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tiled_region_walker i_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_restart,
    .out_valid, .out_stall, .out_piece_valid,
    .out_tile_col_index, .out_tile_row_index,
    .out_offset_in_tile_x, .out_offset_in_tile_y,
    .out_piece_width, .out_piece_height,
    .out_piece_x, .out_piece_y, .out_pixel_offset,
    .out_full_width, .out_full_tile
  );

  twr_piece_checker i_checker (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_restart,
    .out_valid, .out_stall, .out_piece_valid,
    .out_tile_col_index, .out_tile_row_index,
    .out_offset_in_tile_x, .out_offset_in_tile_y,
    .out_piece_width, .out_piece_height,
    .out_piece_x, .out_piece_y, .out_pixel_offset,
    .out_full_width, .out_full_tile,
    .mismatch_count, .pieces_waiting
  );

  // random register values, extremes weighted in
  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return '0;
      3: return 24'hffffff;
      4, 5: return CW'(int'($urandom_range(0, 200)) - 100);
      default: return CW'($urandom());
    endcase
  endfunction

  function automatic logic [CW-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 24'h7fffff;
      2: return CW'($urandom());
      default: return CW'($urandom_range(1, 48));
    endcase
  endfunction

  function automatic logic [CW-1:0] pick_tile();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return CW'(1);
      2: return CW'(4096);
      3: return CW'($urandom_range(4097, 8191));
      4: return CW'($urandom());
      default: return CW'($urandom_range(1, 20));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic close_cfg();
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_data  <= CW'($urandom());
  endtask

  // stop requesting and wait until every outstanding result is back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pieces_waiting != 0) @(negedge clk);
  endtask

  // one request transfer, with bursts and gaps on the sender side
  task automatic issue(input logic restart);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_valid   <= 1'b0;
        in_restart <= 1'($urandom_range(0, 1));
        repeat ($urandom_range(0, 14)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  // receiver stall pattern, with one long hold-off to back the block up
  initial begin
    int mode;
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      if (!hold_done && requests_sent >= 300) begin
        repeat (800) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  initial begin
    #(12 * 1500000);
    $display("FAIL tiled_region_walker");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int phase, walk_len, guard;
    bit fresh;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_restart    = 1'b0;
    requests_sent = 0;
    burst_left    = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // first request with no restart, then a finished walk
    issue(1'b0);
    issue(1'b0);
    issue(1'b0);
    issue(1'b1);
    settle();

    // extreme registers: zero sizes, zero and oversize tiles
    write_reg(REG_REGION_X, 24'h800000);
    write_reg(REG_REGION_Y, 24'h7fffff);
    write_reg(REG_REGION_WIDTH, '0);
    write_reg(REG_REGION_HEIGHT, '0);
    write_reg(REG_TILE_COLS, '0);
    write_reg(REG_TILE_ROWS, CW'(8191));
    write_reg(REG_SHIFT_X, 24'h800000);
    write_reg(REG_SHIFT_Y, 24'h7fffff);
    close_cfg();
    issue(1'b1);
    issue(1'b0);
    issue(1'b0);
    settle();

    // column index wraps past the top of its range
    write_reg(REG_REGION_X, 24'h7fffff);
    write_reg(REG_SHIFT_X, 24'h7fffff);
    write_reg(REG_TILE_COLS, CW'(1));
    write_reg(REG_REGION_WIDTH, CW'(5));
    write_reg(REG_REGION_Y, '0);
    write_reg(REG_SHIFT_Y, 24'hffffff);
    write_reg(REG_TILE_ROWS, CW'(2));
    write_reg(REG_REGION_HEIGHT, CW'(1));
    close_cfg();
    issue(1'b1);
    issue(1'b0);
    issue(1'b0);
    settle();

    // region shrunk mid-walk: column past the edge, then row past the edge
    write_reg(REG_REGION_WIDTH, CW'(2));
    write_reg(REG_REGION_HEIGHT, CW'(3));
    close_cfg();
    issue(1'b0);
    issue(1'b0);
    settle();
    write_reg(REG_REGION_HEIGHT, CW'(1));
    close_cfg();
    issue(1'b0);
    settle();

    // aligned region of whole tiles
    write_reg(REG_REGION_X, '0);
    write_reg(REG_REGION_Y, '0);
    write_reg(REG_SHIFT_X, '0);
    write_reg(REG_SHIFT_Y, '0);
    write_reg(REG_TILE_COLS, CW'(4));
    write_reg(REG_TILE_ROWS, CW'(4));
    write_reg(REG_REGION_WIDTH, CW'(8));
    write_reg(REG_REGION_HEIGHT, CW'(8));
    close_cfg();
    issue(1'b1);
    issue(1'b0);
    issue(1'b0);
    settle();

    // random walks under random settings
    phase = 0;
    while (requests_sent < 1020) begin
      if (phase < 3 || $urandom_range(0, 1)) write_reg(REG_REGION_X, pick_coord());
      if (phase < 3 || $urandom_range(0, 1)) write_reg(REG_REGION_Y, pick_coord());
      if (phase < 3 || $urandom_range(0, 1)) write_reg(REG_REGION_WIDTH, pick_size());
      if (phase < 3 || $urandom_range(0, 1)) write_reg(REG_REGION_HEIGHT, pick_size());
      if (phase < 3 || $urandom_range(0, 1)) write_reg(REG_TILE_COLS, pick_tile());
      if (phase < 3 || $urandom_range(0, 1)) write_reg(REG_TILE_ROWS, pick_tile());
      if (phase < 3 || $urandom_range(0, 1)) write_reg(REG_SHIFT_X, pick_coord());
      if (phase < 3 || $urandom_range(0, 1)) write_reg(REG_SHIFT_Y, pick_coord());
      close_cfg();
      // most walks start fresh, some carry on under the new region
      fresh    = ($urandom_range(0, 3) != 0);
      walk_len = $urandom_range(1, 40);
      for (int k = 0; k < walk_len; k++)
        issue((k == 0) ? fresh : ($urandom_range(0, 99) < 6));
      settle();
      phase++;
    end

    // drain, then give late or stray results time to show
    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (pieces_waiting != 0 && guard < 50000) begin
      @(negedge clk);
      guard++;
    end
    repeat (120) @(negedge clk);
    if (mismatch_count == 0 && pieces_waiting == 0) begin
      $display("PASS tiled_region_walker");
    end else begin
      $display("FAIL tiled_region_walker");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/twr_pkg.sv
sv/twr_div.sv
sv/twr_dp.sv
sv/twr_ctrl.sv
sv/tiled_region_walker.sv
tb/sv/twr_piece_checker.sv
tb/sv/tiled_region_walker_tb.sv
